/* design/ped_pkg.sv */
// Shared types, constants and helpers for the percent-escape decoder.
`timescale 1ns / 1ps
package ped_pkg;

  localparam logic [7:0] PERCENT_CHAR = 8'h25;
  localparam logic [7:0] U_CHAR       = 8'h75;
  localparam int unsigned QUEUE_DEPTH = 4;
  localparam int unsigned BURST_MAX   = 3;
  localparam int unsigned QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int unsigned QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  typedef struct packed {
    logic [7:0] in_byte;
    logic       in_last;
  } in_item_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       out_last;
    logic       malformed;
  } out_item_t;

  // results caused by one input item: cnt of them, items[0] first
  typedef struct packed {
    logic [1:0]                    cnt;
    out_item_t [BURST_MAX-1:0]     items;
  } bundle_t;

  typedef struct packed {
    logic       ok;
    logic [3:0] val;
  } hex_t;

  typedef enum logic [3:0] {
    PH_IDLE = 4'b0001,
    PH_PCT  = 4'b0010,
    PH_HEX1 = 4'b0100,
    PH_UNI  = 4'b1000
  } phase_e;

  function automatic hex_t hex_decode(logic [7:0] c);
    hex_t h;
    h.ok  = 1'b1;
    h.val = 4'd0;
    if (c >= 8'h30 && c <= 8'h39) begin
      h.val = c[3:0];
    end else if ((c >= 8'h61 && c <= 8'h66) || (c >= 8'h41 && c <= 8'h46)) begin
      h.val = c[3:0] + 4'd9;
    end else begin
      h.ok = 1'b0;
    end
    return h;
  endfunction

endpackage

/* design/ped_queue.sv */
// Short queue of result bundles between the front and back parts.
`timescale 1ns / 1ps
module ped_queue (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_i,
  input  ped_pkg::bundle_t  push_data_i,
  input  logic              pop_i,
  output ped_pkg::bundle_t  head_o,
  output logic              full_o,
  output logic              empty_o
);

  ped_pkg::bundle_t                   mem_q [ped_pkg::QUEUE_DEPTH];
  logic [ped_pkg::QPTR_W-1:0]         wr_ptr_q, wr_ptr_d;
  logic [ped_pkg::QPTR_W-1:0]         rd_ptr_q, rd_ptr_d;
  logic [ped_pkg::QCNT_W-1:0]         count_q, count_d;

  assign full_o  = (count_q == ped_pkg::QCNT_W'(ped_pkg::QUEUE_DEPTH));
  assign empty_o = (count_q == '0);
  assign head_o  = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push_i) begin
      wr_ptr_d = wr_ptr_q + 1'b1;
    end
    if (pop_i) begin
      rd_ptr_d = rd_ptr_q + 1'b1;
    end
    if (push_i && !pop_i) begin
      count_d = count_q + 1'b1;
    end else if (pop_i && !push_i) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

endmodule

/* design/ped_front.sv */
// Front part: accepts input bytes, tracks escape state, builds result bundles.
`timescale 1ns / 1ps
module ped_front (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               accept_i,
  input  ped_pkg::in_item_t  in_item_i,
  output logic               push_o,
  output ped_pkg::bundle_t   bundle_o
);

  ped_pkg::phase_e  phase_q, phase_d;
  logic [7:0]       held_q, held_d;
  logic [15:0]      acc_q, acc_d;
  logic [1:0]       ucnt_q, ucnt_d;
  logic             uvalid_q, uvalid_d;

  ped_pkg::bundle_t b;
  ped_pkg::hex_t    hc;
  ped_pkg::hex_t    hh;
  logic [7:0]       c;

  function automatic ped_pkg::bundle_t put_item(ped_pkg::bundle_t bi, logic [7:0] d,
                                                 logic mal);
    ped_pkg::bundle_t bo;
    bo = bi;
    if (bi.cnt != 2'd3) begin
      bo.items[bi.cnt].out_byte  = d;
      bo.items[bi.cnt].out_last  = 1'b0;
      bo.items[bi.cnt].malformed = mal;
      bo.cnt                     = bi.cnt + 2'd1;
    end
    return bo;
  endfunction

  function automatic ped_pkg::bundle_t put_utf8(ped_pkg::bundle_t bi, logic [15:0] cp,
                                                 logic mal);
    ped_pkg::bundle_t bo;
    bo = bi;
    if (cp < 16'h0080) begin
      bo = put_item(bo, cp[7:0], mal);
    end else if (cp < 16'h0800) begin
      bo = put_item(bo, {3'b110, cp[10:6]}, mal);
      bo = put_item(bo, {2'b10, cp[5:0]}, mal);
    end else begin
      bo = put_item(bo, {4'b1110, cp[15:12]}, mal);
      bo = put_item(bo, {2'b10, cp[11:6]}, mal);
      bo = put_item(bo, {2'b10, cp[5:0]}, mal);
    end
    return bo;
  endfunction

  assign c  = in_item_i.in_byte;
  assign hc = ped_pkg::hex_decode(c);
  assign hh = ped_pkg::hex_decode(held_q);

  always_comb begin
    phase_d  = phase_q;
    held_d   = held_q;
    acc_d    = acc_q;
    ucnt_d   = ucnt_q;
    uvalid_d = uvalid_q;
    b        = '0;

    unique case (phase_q)
      ped_pkg::PH_PCT: begin
        if (hc.ok) begin
          held_d  = c;
          phase_d = ped_pkg::PH_HEX1;
        end else if (c == ped_pkg::U_CHAR) begin
          acc_d    = '0;
          ucnt_d   = '0;
          uvalid_d = 1'b1;
          phase_d  = ped_pkg::PH_UNI;
        end else begin
          b       = put_item(b, ped_pkg::PERCENT_CHAR, 1'b1);
          phase_d = ped_pkg::PH_IDLE;
          if (c == ped_pkg::PERCENT_CHAR) begin
            phase_d = ped_pkg::PH_PCT;
          end else begin
            b = put_item(b, c, 1'b0);
          end
        end
      end
      ped_pkg::PH_HEX1: begin
        phase_d = ped_pkg::PH_IDLE;
        if (hc.ok) begin
          b = put_item(b, {hh.val, hc.val}, 1'b0);
        end else begin
          b = put_item(b, ped_pkg::PERCENT_CHAR, 1'b1);
          b = put_item(b, held_q, 1'b1);
          if (c == ped_pkg::PERCENT_CHAR) begin
            phase_d = ped_pkg::PH_PCT;
          end else begin
            b = put_item(b, c, 1'b0);
          end
        end
      end
      ped_pkg::PH_UNI: begin
        if (uvalid_q && hc.ok) begin
          acc_d = {acc_q[11:0], hc.val};
        end else begin
          uvalid_d = 1'b0;
        end
        if (ucnt_q == 2'd3) begin
          b        = put_utf8(b, acc_d, !uvalid_d);
          phase_d  = ped_pkg::PH_IDLE;
          held_d   = '0;
          acc_d    = '0;
          ucnt_d   = '0;
          uvalid_d = 1'b1;
        end else begin
          ucnt_d = ucnt_q + 2'd1;
        end
      end
      default: begin
        phase_d = ped_pkg::PH_IDLE;
        if (c == ped_pkg::PERCENT_CHAR) begin
          phase_d = ped_pkg::PH_PCT;
        end else begin
          b = put_item(b, c, 1'b0);
        end
      end
    endcase

    if (in_item_i.in_last) begin
      if (phase_d == ped_pkg::PH_PCT) begin
        b = put_item(b, ped_pkg::PERCENT_CHAR, 1'b1);
      end else if (phase_d == ped_pkg::PH_HEX1) begin
        b = put_item(b, ped_pkg::PERCENT_CHAR, 1'b1);
        b = put_item(b, held_d, 1'b1);
      end else if (phase_d == ped_pkg::PH_UNI) begin
        b = put_utf8(b, acc_d, 1'b1);
      end
      phase_d  = ped_pkg::PH_IDLE;
      held_d   = '0;
      acc_d    = '0;
      ucnt_d   = '0;
      uvalid_d = 1'b1;
      if (b.cnt != 2'd0) begin
        b.items[b.cnt - 2'd1].out_last = 1'b1;
      end
    end
  end

  assign bundle_o = b;
  assign push_o   = accept_i && (b.cnt != 2'd0);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q  <= ped_pkg::PH_IDLE;
      held_q   <= '0;
      acc_q    <= '0;
      ucnt_q   <= '0;
      uvalid_q <= 1'b1;
    end else if (accept_i) begin
      phase_q  <= phase_d;
      held_q   <= held_d;
      acc_q    <= acc_d;
      ucnt_q   <= ucnt_d;
      uvalid_q <= uvalid_d;
    end
  end

endmodule

/* design/ped_back.sv */
// Back part: drains queued bundles one byte per transfer into the output register.
`timescale 1ns / 1ps
module ped_back (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  ped_pkg::bundle_t    head_i,
  input  logic                empty_i,
  output logic                pop_o,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output ped_pkg::out_item_t  out_item_o
);

  logic                out_valid_q, out_valid_d;
  ped_pkg::out_item_t  out_q, out_d;
  logic [1:0]          idx_q, idx_d;
  logic                load;

  assign load = !out_valid_q || !out_stall_i;

  always_comb begin
    out_valid_d = out_valid_q;
    out_d       = out_q;
    idx_d       = idx_q;
    pop_o       = 1'b0;
    if (load) begin
      out_valid_d = !empty_i;
      if (!empty_i) begin
        out_d = head_i.items[idx_q];
        if (idx_q == head_i.cnt - 2'd1) begin
          pop_o = 1'b1;
          idx_d = '0;
        end else begin
          idx_d = idx_q + 2'd1;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      idx_q       <= '0;
    end else begin
      out_valid_q <= out_valid_d;
      idx_q       <= idx_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q <= out_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;

endmodule

/* design/percent_escape_decoder.sv */
// Top level of the percent-escape decoder.
//
//   channel | direction | handshake           | payload
//   in      | input     | in_valid_i/in_stall_o   | ped_pkg::in_item_t
//   out     | output    | out_valid_o/out_stall_i | ped_pkg::out_item_t
//
// One input byte is taken per cycle while the four-bundle queue has room.
// Each byte yields zero to three output bytes; the back end sends one per cycle
// while not stalled, so the output port sets the sustained rate when bursts
// pile up. First output byte goes through the queue into the output register.
// Reset clears the escape state, the queue pointers and the output valid flag.
`timescale 1ns / 1ps
module percent_escape_decoder (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  ped_pkg::in_item_t   in_item_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output ped_pkg::out_item_t  out_item_o
);

  logic              accept;
  logic              push;
  logic              pop;
  logic              full;
  logic              empty;
  ped_pkg::bundle_t  push_data;
  ped_pkg::bundle_t  head;

  assign in_stall_o = full;
  assign accept     = in_valid_i && !full;

  ped_front u_front (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .accept_i  (accept),
    .in_item_i (in_item_i),
    .push_o    (push),
    .bundle_o  (push_data)
  );

  ped_queue u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (push_data),
    .pop_i       (pop),
    .head_o      (head),
    .full_o      (full),
    .empty_o     (empty)
  );

  ped_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .head_i      (head),
    .empty_i     (empty),
    .pop_o       (pop),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_item_o  (out_item_o)
  );

endmodule

/* design/ped_checker.sv */
// Port-level checker for the percent-escape decoder, bound to the top level.
`timescale 1ns / 1ps
module ped_checker (
  input logic                clk_i,
  input logic                rst_ni,
  input logic                in_valid_i,
  input logic                in_stall_o,
  input logic                out_valid_o,
  input logic                out_stall_i,
  input ped_pkg::out_item_t  out_item_o
);

  // stalled output transfer holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_item_o))
    else $error("output changed while stalled");

  // queue fills only through input transfers
  a_stall_rise: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(in_stall_o) |-> $past(in_valid_i && !in_stall_o))
    else $error("input stall rose without an input transfer");

  // queue drains only when the output register can load
  a_stall_fall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $fell(in_stall_o) |-> $past(!out_valid_o || !out_stall_i))
    else $error("input stall fell without output progress");

  // a full queue implies the output register is occupied
  a_full_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> out_valid_o)
    else $error("queue full with empty output register");

endmodule

bind percent_escape_decoder ped_checker u_ped_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_stall_o  (in_stall_o),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .out_item_o  (out_item_o)
);
